FILE: sv/plb_pkg.sv
// ----------------------------------------------------------------------------
// Positional list buffer package
// Shared widths, operation and status codes, and the per-cell control type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plb_pkg;

   localparam int CAPACITY = 16;

   localparam int DATA_W  = 32;
   localparam int KIND_W  = 2;
   localparam int POS_W   = 5;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = ((OCC_W > POS_W) ? OCC_W : POS_W) + 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ   = 2'd0,
      KIND_WRITE  = 2'd1,
      KIND_INSERT = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_LOAD      = 2'd1,
      CELL_TAKE_PREV = 2'd2,
      CELL_TAKE_NEXT = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [DATA_W-1:0]  data;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: sv/plb_cell.sv
// ----------------------------------------------------------------------------
// Positional list buffer cell
// Holds one list entry; loads new data or takes a neighbor's entry on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plb_cell (
   input  wire logic                              clock,
   input  wire plb_pkg::cell_ctrl_type            ctrl,
   input  wire logic signed [plb_pkg::DATA_W-1:0] prev_value,
   input  wire logic signed [plb_pkg::DATA_W-1:0] next_value,
   output logic signed [plb_pkg::DATA_W-1:0]      value
);
   import plb_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      unique case (ctrl.op)
         CELL_LOAD:      value_in = ctrl.data;
         CELL_TAKE_PREV: value_in = prev_value;
         CELL_TAKE_NEXT: value_in = next_value;
         default:        value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

FILE: sv/positional_list_buffer_unit.sv
// ----------------------------------------------------------------------------
// Positional list buffer unit
// Ordered list of signed values with read, overwrite, insert and remove.
// ----------------------------------------------------------------------------
// The unit accepts one transaction per clock cycle unless stalled and
// registers its response. Every entry sits in its own cell of a chain, so
// an insert or remove shifts all later entries in that same cycle. The input
// is stalled only while a finished response waits on a stalled output.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_buffer_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [plb_pkg::KIND_W-1:0]         req_kind,
   input  wire logic [plb_pkg::POS_W-1:0]          req_position,
   input  wire logic signed [plb_pkg::DATA_W-1:0]  req_data_in,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [plb_pkg::DATA_W-1:0]       rsp_data_out,
   output logic [plb_pkg::STAT_W-1:0]              rsp_status,
   output logic [plb_pkg::COUNT_W-1:0]             rsp_entry_count,
   output logic                                    rsp_is_empty
);
   import plb_pkg::*;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] data_out_ff;
   logic signed [DATA_W-1:0] data_out_in;
   status_type               status_ff;
   status_type               status_in;
   logic [OCC_W-1:0]         occ_ff;
   logic [OCC_W-1:0]         occ_in;

   logic                     accept;
   kind_type                 kind;
   logic [CMP_W-1:0]         pos_c;
   logic [CMP_W-1:0]         occ_c;
   logic [CMP_W-1:0]         idx_c;
   logic                     done_ok;

   cell_ctrl_type            cell_ctrl [CAPACITY];
   logic signed [DATA_W-1:0] cell_value [CAPACITY];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign kind      = kind_type'(req_kind);
   assign pos_c     = CMP_W'(req_position);
   assign occ_c     = CMP_W'(occ_ff);
   assign idx_c     = pos_c - CMP_W'(1);

   always_comb begin
      status_in = ST_OK;
      if (kind == KIND_INSERT) begin
         if ((pos_c == '0) || (pos_c > occ_c + CMP_W'(1))) begin
            status_in = ST_RANGE;
         end else if (occ_c >= CMP_W'(CAPACITY)) begin
            status_in = ST_FULL;
         end
      end else begin
         if ((pos_c == '0) || (pos_c > occ_c)) begin
            status_in = ST_RANGE;
         end
      end
   end

   assign done_ok = accept & (status_in == ST_OK);

   always_comb begin
      occ_in = occ_ff;
      if (done_ok && (kind == KIND_INSERT)) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (done_ok && (kind == KIND_REMOVE)) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_comb begin
      data_out_in = '0;
      if (kind == KIND_READ && status_in == ST_OK) begin
         data_out_in = cell_value[idx_c[IDX_W-1:0]];
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] prev_value;
      logic signed [DATA_W-1:0] next_value;

      always_comb begin
         cell_ctrl[i].data = req_data_in;
         cell_ctrl[i].op   = CELL_HOLD;
         if (done_ok) begin
            unique case (kind)
               KIND_WRITE: begin
                  if (CMP_W'(i) == idx_c) cell_ctrl[i].op = CELL_LOAD;
               end
               KIND_INSERT: begin
                  if (CMP_W'(i) == idx_c) begin
                     cell_ctrl[i].op = CELL_LOAD;
                  end else if (CMP_W'(i) > idx_c) begin
                     cell_ctrl[i].op = CELL_TAKE_PREV;
                  end
               end
               KIND_REMOVE: begin
                  if (CMP_W'(i) >= idx_c) cell_ctrl[i].op = CELL_TAKE_NEXT;
               end
               default: cell_ctrl[i].op = CELL_HOLD;
            endcase
         end
      end

      if (i == 0) begin : g_head
         assign prev_value = '0;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_value = '0;
      end else begin : g_link
         assign next_value = cell_value[i+1];
      end

      plb_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (cell_value[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         occ_ff       <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_out_ff <= data_out_in;
         status_ff   <= status_in;
      end
   end

   logic [OCC_W-1:0] occ_rsp_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         occ_rsp_ff <= occ_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = data_out_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = COUNT_W'(occ_rsp_ff);
   assign rsp_is_empty    = (occ_rsp_ff == '0);

endmodule

`default_nettype wire
